// ===== hw/rtl/gqtl_pkg.sv =====
// ----------------------------------------------------------------------------
// gqtl_pkg
// Shared types, constants and helpers of the glyph quad text layout block.
// ----------------------------------------------------------------------------
package gqtl_pkg;

  localparam int GLYPH_COUNT_DEF = 96;
  localparam int ATLAS_DIM_DEF   = 512;

  // Quads that may be reserved between input and output at one time.
  localparam int QUAD_DEPTH = 4;

  localparam int COORD_W     = 16;
  localparam int ATLAS_W     = 10;
  localparam int SIZE_W      = 19;  // scaled glyph width or height, signed
  localparam int PROD_W      = 34;  // 10 bit magnitude times 24 bit scale
  localparam int LINE_W      = 12;
  localparam int ADV_W       = 10;  // line_height / 10 and line_height / 6
  localparam int SCALE_W     = 24;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Reciprocals for line_height / 10 and / 6, exact for 12 bit operands.
  localparam logic [13:0] RECIP_10 = 14'd6554;
  localparam logic [13:0] RECIP_6  = 14'd10923;

  // Input actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_CHAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y     = 3'd5;

  // Character codes with special handling
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LAST    = 8'h7F;

  // Quad corners
  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BL = 2'd2;
  localparam logic [1:0] CORNER_BR = 2'd3;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_BEGIN,
    KIND_NEWLINE,
    KIND_TAB,
    KIND_SPACE,
    KIND_GLYPH
  } kind_t;

  typedef enum logic [1:0] {
    BASE_NORMAL,
    BASE_DESC,
    BASE_CENTER,
    BASE_TOP
  } base_t;

  typedef struct packed {
    logic [ATLAS_W-1:0] x0;
    logic [ATLAS_W-1:0] y0;
    logic [ATLAS_W-1:0] x1;
    logic [ATLAS_W-1:0] y1;
  } glyph_t;

  typedef struct packed {
    kind_t kind;
    base_t base;
  } item_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [14:0]        wrap_width;
    logic [LINE_W-1:0]  line_height;
    logic [ADV_W-1:0]   gap10;
    logic [ADV_W-1:0]   space6;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] xr;
    logic [COORD_W-1:0] yt;
    logic [COORD_W-1:0] yb;
    glyph_t             tex;
  } quad_t;

  function automatic base_t decode_base(input logic [7:0] code);
    base_t b;
    unique case (code)
      "g", "j", "p", "q", "y":      b = BASE_DESC;
      "+", "-", "<", "=", ">", "~": b = BASE_CENTER;
      "\"", "'", "*", "^":          b = BASE_TOP;
      default:                      b = BASE_NORMAL;
    endcase
    return b;
  endfunction

  function automatic logic [ATLAS_W-1:0] sat_atlas(input logic [ATLAS_W-1:0] v,
                                                   input logic [12:0] dim);
    return ({3'd0, v} > dim) ? dim[ATLAS_W-1:0] : v;
  endfunction

endpackage

// ===== hw/rtl/glyph_quad_text_layout.sv =====
// A glyph passes the layout pipe and the quad queue before its first vertex is offered.
// Throughput: one item per cycle while in_tready is high; a visible glyph occupies the
// vertex output for four vertices, so the one-vertex result port limits glyph streams.
// Up to four quads may be held between input and output before in_tready drops.
// Reset (synchronous, rst_n low) clears the pen, the vertex counter, the queue and the
// registers to their defaults; the glyph table is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
// glyph_quad_text_layout
// Lays out a stream of characters as textured glyph quads, four vertices each.
// ----------------------------------------------------------------------------
module glyph_quad_text_layout #(
  parameter int GLYPH_COUNT = gqtl_pkg::GLYPH_COUNT_DEF,
  parameter int ATLAS_DIM   = gqtl_pkg::ATLAS_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // char_code, glyph_slot, atlas_x0, atlas_y0, atlas_x1, atlas_y1, zero pad
  input  logic [gqtl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pos_x, pos_y, tex_x, tex_y, vertex_index, zero pad
  output logic [gqtl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // corner
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [gqtl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gqtl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ADDR_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  logic [1:0]       in_action;
  logic [7:0]       in_code;
  logic [6:0]       in_slot;
  gqtl_pkg::glyph_t in_glyph;

  logic                acc;
  logic [7:0]          slot_ext;
  logic                in_table, visible;
  gqtl_pkg::item_ctl_t ctl;
  logic                mem_wr, mem_rd;
  gqtl_pkg::glyph_t    rd_glyph;

  gqtl_pkg::cfg_t cfg_r, cfg_nxt;
  logic [25:0]    div10_prod, div6_prod;

  logic            has_room, quad_vld;
  gqtl_pkg::quad_t quad;

  logic [15:0] vtx_x, vtx_y, vtx_index;
  logic [9:0]  vtx_tex_x, vtx_tex_y;

  assign in_code     = in_tdata[7:0];
  assign in_slot     = in_tdata[14:8];
  assign in_glyph.x0 = in_tdata[24:15];
  assign in_glyph.y0 = in_tdata[34:25];
  assign in_glyph.x1 = in_tdata[44:35];
  assign in_glyph.y1 = in_tdata[54:45];
  assign in_action   = in_tuser;

  assign in_tready = has_room;
  assign acc       = in_tvalid && in_tready;

  // Table slot of a load, or of a printable character.
  always_comb begin
    slot_ext = (in_action == gqtl_pkg::ACT_LOAD) ? {1'b0, in_slot}
                                                 : (in_code - gqtl_pkg::CH_SPACE);
    in_table = {1'b0, slot_ext} < 9'(GLYPH_COUNT);
    visible  = (in_code > gqtl_pkg::CH_SPACE) && (in_code <= gqtl_pkg::CH_LAST) && in_table;
  end

  always_comb begin
    ctl.base = gqtl_pkg::decode_base(in_code);
    ctl.kind = gqtl_pkg::KIND_NOP;
    unique case (in_action)
      gqtl_pkg::ACT_BEGIN: ctl.kind = gqtl_pkg::KIND_BEGIN;
      gqtl_pkg::ACT_CHAR: begin
        priority if (in_code == gqtl_pkg::CH_NEWLINE) begin
          ctl.kind = gqtl_pkg::KIND_NEWLINE;
        end else if (in_code == gqtl_pkg::CH_TAB) begin
          ctl.kind = gqtl_pkg::KIND_TAB;
        end else if (in_code == gqtl_pkg::CH_SPACE) begin
          ctl.kind = gqtl_pkg::KIND_SPACE;
        end else if (visible) begin
          ctl.kind = gqtl_pkg::KIND_GLYPH;
        end else begin
          ctl.kind = gqtl_pkg::KIND_NOP;
        end
      end
      default: ctl.kind = gqtl_pkg::KIND_NOP;
    endcase
  end

  assign mem_wr = acc && (in_action == gqtl_pkg::ACT_LOAD) && in_table;
  assign mem_rd = acc && ((ctl.kind == gqtl_pkg::KIND_GLYPH) ||
                          (ctl.kind == gqtl_pkg::KIND_SPACE));

  // ---- configuration registers ----
  always_comb begin
    div10_prod = 26'(cfg_wdata[11:0]) * 26'(gqtl_pkg::RECIP_10);
    div6_prod  = 26'(cfg_wdata[11:0]) * 26'(gqtl_pkg::RECIP_6);
    cfg_nxt    = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        gqtl_pkg::CFG_ORIGIN_X:   cfg_nxt.origin_x   = cfg_wdata[15:0];
        gqtl_pkg::CFG_ORIGIN_Y:   cfg_nxt.origin_y   = cfg_wdata[15:0];
        gqtl_pkg::CFG_WRAP_WIDTH: cfg_nxt.wrap_width = cfg_wdata[14:0];
        gqtl_pkg::CFG_LINE_HEIGHT: begin
          cfg_nxt.line_height = cfg_wdata[11:0];
          cfg_nxt.gap10       = div10_prod[25:16];
          cfg_nxt.space6      = div6_prod[25:16];
        end
        gqtl_pkg::CFG_SCALE_X:    cfg_nxt.scale_x    = cfg_wdata;
        gqtl_pkg::CFG_SCALE_Y:    cfg_nxt.scale_y    = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.wrap_width  <= 15'd32767;
      cfg_r.line_height <= 12'd16;
      cfg_r.gap10       <= 10'd1;
      cfg_r.space6      <= 10'd2;
      cfg_r.scale_x     <= 24'd65536;
      cfg_r.scale_y     <= 24'd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gqtl_glyph_store #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .ATLAS_DIM   (ATLAS_DIM),
    .ADDR_W      (ADDR_W)
  ) u_glyph_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (slot_ext[ADDR_W-1:0]),
    .wr_data (in_glyph),
    .rd_en   (mem_rd),
    .rd_addr (slot_ext[ADDR_W-1:0]),
    .rd_data (rd_glyph)
  );

  gqtl_layout_pipe u_layout_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (acc),
    .item_ctl (ctl),
    .rd_glyph (rd_glyph),
    .cfg      (cfg_r),
    .quad_vld (quad_vld),
    .quad     (quad)
  );

  gqtl_quad_out u_quad_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .reserve    (acc && (ctl.kind == gqtl_pkg::KIND_GLYPH)),
    .has_room   (has_room),
    .push       (quad_vld),
    .quad       (quad),
    .vtx_valid  (out_tvalid),
    .vtx_ready  (out_tready),
    .vtx_x      (vtx_x),
    .vtx_y      (vtx_y),
    .vtx_tex_x  (vtx_tex_x),
    .vtx_tex_y  (vtx_tex_y),
    .vtx_corner (out_tuser),
    .vtx_index  (vtx_index),
    .vtx_last   (out_tlast)
  );

  assign out_tdata = {4'd0, vtx_index, vtx_tex_y, vtx_tex_x, vtx_y, vtx_x};

endmodule

// ===== hw/rtl/gqtl_glyph_store.sv =====
// ----------------------------------------------------------------------------
// gqtl_glyph_store
// Glyph table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gqtl_glyph_store #(
  parameter int GLYPH_COUNT = gqtl_pkg::GLYPH_COUNT_DEF,
  parameter int ATLAS_DIM   = gqtl_pkg::ATLAS_DIM_DEF,
  parameter int ADDR_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  gqtl_pkg::glyph_t    wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output gqtl_pkg::glyph_t    rd_data
);

  localparam logic [12:0] DIM = 13'(ATLAS_DIM);

  gqtl_pkg::glyph_t glyph_mem_r [GLYPH_COUNT];
  gqtl_pkg::glyph_t rd_data_r;
  gqtl_pkg::glyph_t sat_data;

  // Boxes are clamped to the atlas as they are stored.
  always_comb begin
    sat_data.x0 = gqtl_pkg::sat_atlas(wr_data.x0, DIM);
    sat_data.y0 = gqtl_pkg::sat_atlas(wr_data.y0, DIM);
    sat_data.x1 = gqtl_pkg::sat_atlas(wr_data.x1, DIM);
    sat_data.y1 = gqtl_pkg::sat_atlas(wr_data.y1, DIM);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      glyph_mem_r[wr_addr] <= sat_data;
    end
    if (rd_en) begin
      rd_data_r <= glyph_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/gqtl_layout_pipe.sv =====
// ----------------------------------------------------------------------------
// gqtl_layout_pipe
// Scales the glyph box, works out the baseline offset, moves the pen and
// forms the four corners of each visible quad.
// ----------------------------------------------------------------------------
module gqtl_layout_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  gqtl_pkg::item_ctl_t item_ctl,
  input  gqtl_pkg::glyph_t    rd_glyph,
  input  gqtl_pkg::cfg_t      cfg,
  output logic                quad_vld,
  output gqtl_pkg::quad_t     quad
);

  localparam int SW = gqtl_pkg::SIZE_W;
  localparam int CW = gqtl_pkg::COORD_W;
  localparam int PW = gqtl_pkg::PROD_W;
  localparam int AW = gqtl_pkg::ATLAS_W;

  // Stage 1: glyph box arrives from the table
  logic                s1_vld_r;
  gqtl_pkg::item_ctl_t s1_ctl_r;

  logic          negx, negy;
  logic [AW-1:0] magx, magy;
  logic [PW-1:0] prodx, prody;

  // Stage 2: scaled magnitudes
  logic                s2_vld_r;
  gqtl_pkg::item_ctl_t s2_ctl_r;
  gqtl_pkg::glyph_t    s2_glyph_r;
  logic                s2_negx_r, s2_negy_r;
  logic [PW-1:0]       s2_prodx_r, s2_prody_r;

  logic signed [SW-1:0] w_nxt, h_nxt;
  logic [CW-1:0]        wg_nxt;

  // Stage 3: signed width and height
  logic                 s3_vld_r;
  gqtl_pkg::item_ctl_t  s3_ctl_r;
  gqtl_pkg::glyph_t     s3_glyph_r;
  logic signed [SW-1:0] s3_w_r, s3_h_r;
  logic [CW-1:0]        s3_wg_r;

  logic signed [20:0] h3, h3_adj;
  logic signed [19:0] cd, cd_adj;
  logic [CW-1:0]      off_nxt;

  // Stage 4: baseline offset
  logic                 s4_vld_r;
  gqtl_pkg::kind_t      s4_kind_r;
  gqtl_pkg::glyph_t     s4_glyph_r;
  logic signed [SW-1:0] s4_w_r;
  logic [CW-1:0]        s4_h_r, s4_wg_r, s4_off_r;

  // Pen stage
  logic [CW-1:0]      pen_x_r, pen_y_r, pen_x_nxt, pen_y_nxt;
  logic [CW-1:0]      line16, bx, by;
  logic signed [20:0] reach, limit;
  logic               wrap;

  // Stage 5: quad base point
  logic             s5_vld_r;
  gqtl_pkg::glyph_t s5_glyph_r;
  logic [CW-1:0]    s5_px_r, s5_py_r, s5_w_r, s5_h_r, s5_off_r;
  logic [CW-1:0]    yt;

  // ---- stage 1 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= item_vld;
    end
    s1_ctl_r <= item_ctl;
  end

  // Truncation toward zero: scale the magnitude and restore the sign later.
  always_comb begin
    negx  = rd_glyph.x1 < rd_glyph.x0;
    negy  = rd_glyph.y1 < rd_glyph.y0;
    magx  = negx ? (rd_glyph.x0 - rd_glyph.x1) : (rd_glyph.x1 - rd_glyph.x0);
    magy  = negy ? (rd_glyph.y0 - rd_glyph.y1) : (rd_glyph.y1 - rd_glyph.y0);
    prodx = PW'(magx) * PW'(cfg.scale_x);
    prody = PW'(magy) * PW'(cfg.scale_y);
  end

  // ---- stage 2 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_ctl_r   <= s1_ctl_r;
    s2_glyph_r <= rd_glyph;
    s2_negx_r  <= negx;
    s2_negy_r  <= negy;
    s2_prodx_r <= prodx;
    s2_prody_r <= prody;
  end

  always_comb begin
    w_nxt  = s2_negx_r ? (SW'(0) - {1'b0, s2_prodx_r[PW-1:16]}) : {1'b0, s2_prodx_r[PW-1:16]};
    h_nxt  = s2_negy_r ? (SW'(0) - {1'b0, s2_prody_r[PW-1:16]}) : {1'b0, s2_prody_r[PW-1:16]};
    wg_nxt = w_nxt[CW-1:0] + CW'(cfg.gap10);
  end

  // ---- stage 3 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_ctl_r   <= s2_ctl_r;
    s3_glyph_r <= s2_glyph_r;
    s3_w_r     <= w_nxt;
    s3_h_r     <= h_nxt;
    s3_wg_r    <= wg_nxt;
  end

  // Signed halving and quartering round toward zero.
  always_comb begin
    h3     = 21'(s3_h_r) + (21'(s3_h_r) <<< 1);
    h3_adj = (h3 + (h3[20] ? 21'sd3 : 21'sd0)) >>> 2;
    cd     = $signed({8'd0, cfg.line_height}) - 20'(s3_h_r);
    cd_adj = (cd + (cd[19] ? 20'sd1 : 20'sd0)) >>> 1;
    unique case (s3_ctl_r.base)
      gqtl_pkg::BASE_DESC:   off_nxt = h3_adj[CW-1:0];
      gqtl_pkg::BASE_CENTER: off_nxt = cd_adj[CW-1:0];
      gqtl_pkg::BASE_TOP:    off_nxt = CW'(cfg.line_height);
      default:               off_nxt = s3_h_r[CW-1:0];
    endcase
  end

  // ---- stage 4 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_kind_r  <= s3_ctl_r.kind;
    s4_glyph_r <= s3_glyph_r;
    s4_w_r     <= s3_w_r;
    s4_h_r     <= s3_h_r[CW-1:0];
    s4_wg_r    <= s3_wg_r;
    s4_off_r   <= off_nxt;
  end

  // ---- pen stage: the only place the pen is read and written ----
  always_comb begin
    line16 = CW'(cfg.line_height);
    reach  = 21'($signed(pen_x_r)) + 21'(s4_w_r);
    limit  = 21'($signed(cfg.origin_x)) + $signed({6'd0, cfg.wrap_width});
    wrap   = reach > limit;
    bx     = wrap ? cfg.origin_x : pen_x_r;
    by     = wrap ? (pen_y_r + line16) : pen_y_r;
  end

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (s4_vld_r) begin
      unique case (s4_kind_r)
        gqtl_pkg::KIND_BEGIN: begin
          pen_x_nxt = cfg.origin_x;
          pen_y_nxt = cfg.origin_y - line16;
        end
        gqtl_pkg::KIND_NEWLINE: begin
          pen_x_nxt = cfg.origin_x;
          pen_y_nxt = pen_y_r + line16;
        end
        gqtl_pkg::KIND_TAB: begin
          pen_x_nxt = pen_x_r + {3'd0, cfg.line_height, 1'b0};
        end
        gqtl_pkg::KIND_SPACE: begin
          pen_x_nxt = bx + CW'(cfg.space6);
          pen_y_nxt = by;
        end
        gqtl_pkg::KIND_GLYPH: begin
          pen_x_nxt = bx + s4_wg_r;
          pen_y_nxt = by;
        end
        default: begin
          pen_x_nxt = pen_x_r;
          pen_y_nxt = pen_y_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r  <= '0;
      pen_y_r  <= '0;
      s5_vld_r <= 1'b0;
    end else begin
      pen_x_r  <= pen_x_nxt;
      pen_y_r  <= pen_y_nxt;
      s5_vld_r <= s4_vld_r && (s4_kind_r == gqtl_pkg::KIND_GLYPH);
    end
    s5_glyph_r <= s4_glyph_r;
    s5_px_r    <= bx;
    s5_py_r    <= by;
    s5_w_r     <= s4_w_r[CW-1:0];
    s5_h_r     <= s4_h_r;
    s5_off_r   <= s4_off_r;
  end

  // ---- stage 5: corners ----
  always_comb begin
    yt       = s5_py_r - s5_off_r;
    quad.xl  = s5_px_r;
    quad.xr  = s5_px_r + s5_w_r;
    quad.yt  = yt;
    quad.yb  = yt + s5_h_r;
    quad.tex = s5_glyph_r;
  end

  assign quad_vld = s5_vld_r;

endmodule

// ===== hw/rtl/gqtl_quad_out.sv =====
// ----------------------------------------------------------------------------
// gqtl_quad_out
// Quad queue with slot reservation, and the sequencer that sends each quad
// as four vertices.
// ----------------------------------------------------------------------------
module gqtl_quad_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                reserve,
  output logic                has_room,
  input  logic                push,
  input  gqtl_pkg::quad_t     quad,
  output logic                vtx_valid,
  input  logic                vtx_ready,
  output logic [15:0]         vtx_x,
  output logic [15:0]         vtx_y,
  output logic [9:0]          vtx_tex_x,
  output logic [9:0]          vtx_tex_y,
  output logic [1:0]          vtx_corner,
  output logic [15:0]         vtx_index,
  output logic                vtx_last
);

  localparam int DEPTH = gqtl_pkg::QUAD_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gqtl_pkg::quad_t quad_mem_r [DEPTH];
  gqtl_pkg::quad_t head;

  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] fill_r, fill_nxt, resv_r, resv_nxt;
  logic [1:0]       corner_r;
  logic [15:0]      vcount_r;
  logic             take, pop;

  assign take     = vtx_valid && vtx_ready;
  assign pop      = take && (corner_r == gqtl_pkg::CORNER_BR);
  assign vtx_valid = fill_r != '0;
  // A slot is held from acceptance of the character until its last vertex.
  assign has_room = resv_r < CNT_W'(DEPTH);
  assign head     = quad_mem_r[rptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
    resv_nxt = resv_r;
    if (reserve && !pop) begin
      resv_nxt = resv_r + 1'b1;
    end else if (pop && !reserve) begin
      resv_nxt = resv_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      rptr_r   <= '0;
      fill_r   <= '0;
      resv_r   <= '0;
      corner_r <= gqtl_pkg::CORNER_TL;
      vcount_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      resv_r <= resv_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (take) begin
        corner_r <= corner_r + 2'd1;
        vcount_r <= vcount_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      quad_mem_r[wptr_r] <= quad;
    end
  end

  always_comb begin
    unique case (corner_r)
      gqtl_pkg::CORNER_TL: begin
        vtx_x     = head.xl;
        vtx_y     = head.yt;
        vtx_tex_x = head.tex.x0;
        vtx_tex_y = head.tex.y0;
      end
      gqtl_pkg::CORNER_TR: begin
        vtx_x     = head.xr;
        vtx_y     = head.yt;
        vtx_tex_x = head.tex.x1;
        vtx_tex_y = head.tex.y0;
      end
      gqtl_pkg::CORNER_BL: begin
        vtx_x     = head.xl;
        vtx_y     = head.yb;
        vtx_tex_x = head.tex.x0;
        vtx_tex_y = head.tex.y1;
      end
      default: begin
        vtx_x     = head.xr;
        vtx_y     = head.yb;
        vtx_tex_x = head.tex.x1;
        vtx_tex_y = head.tex.y1;
      end
    endcase
  end

  assign vtx_corner = corner_r;
  assign vtx_index  = vcount_r;
  assign vtx_last   = corner_r == gqtl_pkg::CORNER_BR;

endmodule

// ===== hw/rtl/gqtl_checker.sv =====
// ----------------------------------------------------------------------------
// gqtl_checker
// Port-level checks of the vertex stream of the glyph quad text layout block.
// ----------------------------------------------------------------------------
module gqtl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gqtl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tlast
);

  // After reset the queue is empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("vertex offered straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled vertex changed or vanished");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == gqtl_pkg::CORNER_BR)))
    else $error("last flag does not match bottom-right corner");

  // A quad is never broken up: its remaining corners follow in order.
  a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast
      |=> out_tvalid && (out_tuser == $past(out_tuser) + 2'd1))
    else $error("quad corners out of sequence");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> out_tdata[67:52] == $past(out_tdata[67:52]) + 16'd1)
    else $error("vertex index did not advance by one");

endmodule

bind glyph_quad_text_layout gqtl_checker u_gqtl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
